FILE: rtl/core/shift_register_expander_driver_assert.svh
// assertion macros shared by the checker of the shift register expander driver
`ifndef SHIFT_REGISTER_EXPANDER_DRIVER_ASSERT_SVH
`define SHIFT_REGISTER_EXPANDER_DRIVER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SRED_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define SRED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/sred_pkg.sv
// ----------------------------------------------------------------------------
// sred_pkg
// Shared types and constants of the shift register expander driver.
// ----------------------------------------------------------------------------
package sred_pkg;

  localparam int CFG_W    = 4;
  localparam int ACTION_W = 3;
  localparam int BITIDX_W = 6;
  localparam int CHIPIX_W = 3;
  localparam int BYTE_W   = 8;

  // action codes of an input word
  typedef enum logic [ACTION_W-1:0] {
    ACT_SET_BIT  = 3'd0,
    ACT_SET_CHIP = 3'd1,
    ACT_ALL_OFF  = 3'd2,
    ACT_ALL_ON   = 3'd3,
    ACT_SHIFT    = 3'd4
  } action_t;

  // controller states
  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_SHIFT = 1'b1
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;  // input word taken this cycle
    logic start;   // clear bit counter for a shift-out run
    logic step;    // load next serial bit into output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;     // no chip in use
    logic last;      // bit counter points at final bit of run
    logic out_free;  // output register can take a new word
  } sts_t;

endpackage

FILE: rtl/core/sred_ctrl.sv
// ----------------------------------------------------------------------------
// sred_ctrl
// Controller state machine: takes input words and sequences shift-out runs.
// ----------------------------------------------------------------------------
module sred_ctrl
  import sred_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ACTION_W-1:0] action,
  input  sts_t                sts,
  output cmd_t                cmd
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && (action == ACT_SHIFT) && !sts.empty) begin
          cmd.start  = 1'b1;
          state_next = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (sts.out_free) begin
          cmd.step = 1'b1;
          if (sts.last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/sred_datapath.sv
// ----------------------------------------------------------------------------
// sred_datapath
// Shadow byte store, chip count register, bit counter and output register.
// ----------------------------------------------------------------------------
module sred_datapath
  import sred_pkg::*;
#(
  parameter int MAX_CHIPS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CFG_W-1:0]    cfg_wdata,
  input  logic [ACTION_W-1:0] action,
  input  logic [BITIDX_W-1:0] bit_index,
  input  logic [CHIPIX_W-1:0] chip_index,
  input  logic [BYTE_W-1:0]   value,
  input  cmd_t                cmd,
  output sts_t                sts,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                serial_bit,
  output logic                latch
);

  localparam int CHIP_W = (MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1;
  localparam int CNT_W  = CHIP_W + 3;
  localparam logic [CFG_W-1:0] MAX_N = CFG_W'(MAX_CHIPS);

  logic [BYTE_W-1:0] shadow      [MAX_CHIPS];
  logic [BYTE_W-1:0] shadow_next [MAX_CHIPS];
  logic [CFG_W-1:0]  chip_count;
  logic [CFG_W-1:0]  n_use;
  logic [CFG_W-1:0]  n_m1;
  logic [CFG_W-1:0]  bit_byte;
  logic [CFG_W-1:0]  chip_byte;
  logic              bit_in_range;
  logic              chip_in_range;
  logic [CNT_W-1:0]  cnt;
  logic [CHIP_W-1:0] cnt_byte;
  logic [2:0]        cnt_bit;
  logic [BYTE_W-1:0] cur_byte;

  // chip count register; the count in use is clamped to the store depth
  always_ff @(posedge clk) begin
    if (rst) begin
      chip_count <= CFG_W'(1);
    end else if (cfg_we) begin
      chip_count <= cfg_wdata;
    end
  end

  assign n_use = (chip_count > MAX_N) ? MAX_N : chip_count;
  assign n_m1  = n_use - CFG_W'(1);

  // target bytes of set bit and set chip byte (chain order is reversed)
  assign bit_in_range  = {1'b0, bit_index[5:3]} < n_use;
  assign chip_in_range = {1'b0, chip_index} < n_use;
  assign bit_byte      = n_m1 - {1'b0, bit_index[5:3]};
  assign chip_byte     = n_m1 - {1'b0, chip_index};

  // shadow store update
  always_comb begin
    for (int i = 0; i < MAX_CHIPS; i++) begin
      shadow_next[i] = shadow[i];
    end
    if (cmd.accept) begin
      case (action)
        ACT_SET_BIT: begin
          for (int i = 0; i < MAX_CHIPS; i++) begin
            if (bit_in_range && (CFG_W'(i) == bit_byte)) begin
              shadow_next[i][~bit_index[2:0]] = value[0];
            end
          end
        end
        ACT_SET_CHIP: begin
          for (int i = 0; i < MAX_CHIPS; i++) begin
            if (chip_in_range && (CFG_W'(i) == chip_byte)) begin
              shadow_next[i] = value;
            end
          end
        end
        ACT_ALL_OFF, ACT_ALL_ON: begin
          for (int i = 0; i < MAX_CHIPS; i++) begin
            if (CFG_W'(i) < n_use) begin
              shadow_next[i] = (action == ACT_ALL_ON) ? '1 : '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CHIPS; i++) begin
        shadow[i] <= '0;
      end
    end else begin
      for (int i = 0; i < MAX_CHIPS; i++) begin
        shadow[i] <= shadow_next[i];
      end
    end
  end

  // bit counter for a shift-out run
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.start) begin
      cnt <= '0;
    end else if (cmd.step) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  assign cnt_byte = cnt[CNT_W-1:3];
  assign cnt_bit  = cnt[2:0];
  assign cur_byte = shadow[cnt_byte];

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      serial_bit <= cur_byte[cnt_bit];
      latch      <= sts.last;
    end
  end

  // status
  assign sts.empty    = (n_use == '0);
  assign sts.last     = (CFG_W'(cnt_byte) == n_m1) && (cnt_bit == 3'd7);
  assign sts.out_free = !out_valid || out_ready;

endmodule

FILE: rtl/core/shift_register_expander_driver.sv
// ----------------------------------------------------------------------------
// shift_register_expander_driver
// Shadow store and serializer for a chain of eight-bit output shift registers.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one action word: set bit, set
// chip byte, all off, all on or shift out. Output channel (out_valid/
// out_ready) carries one serial_bit per word, latch high on the final bit.
// cfg_we/cfg_wdata write chip_count; write only while the block is idle.
// Edit actions leave in_ready high, and the next word can follow in the
// next cycle. Shift out of n chips gives n*8 output words; the first is
// loaded into the output register once the controller is in its shift
// state and the register is free, then one per cycle while out_ready is
// high, as the bit counter walks the shadow store. in_ready is low during
// the run and rises as the final bit is loaded into the output register.
// A stalled receiver holds the output register and stops the bit counter.
// Reset clears all shadow bytes, sets chip_count to one, and empties the
// output register.
// ----------------------------------------------------------------------------
module shift_register_expander_driver
  import sred_pkg::*;
#(
  parameter int MAX_CHIPS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CFG_W-1:0]    cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ACTION_W-1:0] action,
  input  logic [BITIDX_W-1:0] bit_index,
  input  logic [CHIPIX_W-1:0] chip_index,
  input  logic [BYTE_W-1:0]   value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                serial_bit,
  output logic                latch
);

  cmd_t cmd;
  sts_t sts;

  // controller
  sred_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  sred_datapath #(
    .MAX_CHIPS (MAX_CHIPS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .action     (action),
    .bit_index  (bit_index),
    .chip_index (chip_index),
    .value      (value),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .serial_bit (serial_bit),
    .latch      (latch)
  );

endmodule

FILE: rtl/core/sred_checker.sv
// ----------------------------------------------------------------------------
// sred_checker
// Port-level checks of the shift register expander driver, bound to the top.
// ----------------------------------------------------------------------------
`include "shift_register_expander_driver_assert.svh"

module sred_checker
  import sred_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic [ACTION_W-1:0] action,
  input logic                out_valid,
  input logic                out_ready,
  input logic                serial_bit,
  input logic                latch
);

  // stalled output word holds
  `SRED_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(serial_bit) && $stable(latch), "output word changed while stalled")

  // an edit word produces no output word
  `SRED_ASSERT_NEXT(a_edit_silent, in_valid && in_ready && (action != ACT_SHIFT) && !out_valid, !out_valid, "output word after an edit action")

  // mid-run bit delivered while the block is busy
  `SRED_ASSERT_NOW(a_busy_mid_run, out_valid && out_ready && !latch, !in_ready, "input taken during a shift-out run")

  // block stays free after the final bit when no new word is offered
  `SRED_ASSERT_NEXT(a_free_after_latch, out_valid && out_ready && latch && in_ready && !in_valid, in_ready, "block still busy after final bit")

endmodule

bind shift_register_expander_driver sred_checker u_sred_checker (.*);

FILE: tb/sv/shift_register_expander_driver_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shift_register_expander_driver_test
// Self-checking bench for the shift register expander driver. A directed table
// covers reset state, the all-on/all-off/set actions, out-of-range indices,
// spare action codes and the chip count extremes, including zero and values
// above the chain length. Random words follow under three idle mixes and
// several chip counts. A bench shadow-store model predicts each serial word
// and latch strobe but for typed rows; the output channel is checked in order.
// ----------------------------------------------------------------------------
module shift_register_expander_driver_test;
  import sred_pkg::*;

  localparam int MAX_CHIPS   = 8;
  localparam int SETTLE      = 4;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int SEG_WORDS   = 30;

  // action codes the block does not define
  localparam logic [ACTION_W-1:0] ACT_SPARE_5 = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

  localparam bit WORD_ROW  = 1'b0;
  localparam bit CFG_ROW   = 1'b1;
  localparam bit PREDICTED = 1'b0;
  localparam bit TYPED     = 1'b1;

  typedef struct packed {
    logic serial_bit;
    logic latch;
  } serial_word_t;

  typedef struct packed {
    logic                is_cfg;
    logic [CFG_W-1:0]    chips;
    logic [ACTION_W-1:0] act;
    logic [BITIDX_W-1:0] bit_idx;
    logic [CHIPIX_W-1:0] chip_idx;
    logic [BYTE_W-1:0]   val;
    logic                typed;
    logic [6:0]          run_len;
    logic [63:0]         run_bits;
  } dir_row_t;

  localparam int DIR_ROWS = 31;

  // directed table; typed rows carry the serial run read straight off the spec
  localparam dir_row_t DIRECTED_ROWS [0:DIR_ROWS-1] = '{
    '{WORD_ROW, 4'd0,  ACT_SHIFT,    6'd0,  3'd0, 8'h00, TYPED,     7'd8,  64'h00},
    '{WORD_ROW, 4'd0,  ACT_ALL_ON,   6'd0,  3'd0, 8'h00, PREDICTED, 7'd0,  64'h00},
    '{WORD_ROW, 4'd0,  ACT_SHIFT,    6'd0,  3'd0, 8'h00, TYPED,     7'd8,  64'hFF},
    '{WORD_ROW, 4'd0,  ACT_ALL_OFF,  6'd0,  3'd0, 8'h00, PREDICTED, 7'd0,  64'h00},
    '{WORD_ROW, 4'd0,  ACT_SET_BIT,  6'd0,  3'd0, 8'h01, PREDICTED, 7'd0,  64'h00},
    '{WORD_ROW, 4'd0,  ACT_SET_BIT,  6'd8,  3'd0, 8'h01, PREDICTED, 7'd0,  64'h00},
    '{WORD_ROW, 4'd0,  ACT_SET_CHIP, 6'd0,  3'd1, 8'h55, PREDICTED, 7'd0,  64'h00},
    '{WORD_ROW, 4'd0,  ACT_SHIFT,    6'd0,  3'd0, 8'h00, TYPED,     7'd8,  64'h80},
    '{WORD_ROW, 4'd0,  ACT_SET_CHIP, 6'd0,  3'd0, 8'hA5, PREDICTED, 7'd0,  64'h00},
    '{WORD_ROW, 4'd0,  ACT_SPARE_7,  6'd63, 3'd7, 8'hFF, PREDICTED, 7'd0,  64'h00},
    '{WORD_ROW, 4'd0,  ACT_SHIFT,    6'd0,  3'd0, 8'h00, TYPED,     7'd8,  64'hA5},
    '{CFG_ROW,  4'd8,  ACT_SET_BIT,  6'd0,  3'd0, 8'h00, PREDICTED, 7'd0,  64'h00},
    '{WORD_ROW, 4'd0,  ACT_SET_CHIP, 6'd0,  3'd7, 8'h3C, PREDICTED, 7'd0,  64'h00},
    '{WORD_ROW, 4'd0,  ACT_SET_BIT,  6'd63, 3'd0, 8'hFF, PREDICTED, 7'd0,  64'h00},
    '{WORD_ROW, 4'd0,  ACT_SET_BIT,  6'd56, 3'd0, 8'hFE, PREDICTED, 7'd0,  64'h00},
    '{WORD_ROW, 4'd0,  ACT_SHIFT,    6'd0,  3'd0, 8'h00, PREDICTED, 7'd0,  64'h00},
    '{CFG_ROW,  4'd0,  ACT_SET_BIT,  6'd0,  3'd0, 8'h00, PREDICTED, 7'd0,  64'h00},
    '{WORD_ROW, 4'd0,  ACT_ALL_ON,   6'd0,  3'd0, 8'h00, PREDICTED, 7'd0,  64'h00},
    '{WORD_ROW, 4'd0,  ACT_SET_BIT,  6'd0,  3'd0, 8'h01, PREDICTED, 7'd0,  64'h00},
    '{WORD_ROW, 4'd0,  ACT_SHIFT,    6'd0,  3'd0, 8'h00, TYPED,     7'd0,  64'h00},
    '{CFG_ROW,  4'd15, ACT_SET_BIT,  6'd0,  3'd0, 8'h00, PREDICTED, 7'd0,  64'h00},
    '{WORD_ROW, 4'd0,  ACT_SHIFT,    6'd0,  3'd0, 8'h00, PREDICTED, 7'd0,  64'h00},
    '{WORD_ROW, 4'd0,  ACT_ALL_OFF,  6'd0,  3'd0, 8'h00, PREDICTED, 7'd0,  64'h00},
    '{WORD_ROW, 4'd0,  ACT_SHIFT,    6'd0,  3'd0, 8'h00, TYPED,     7'd64, 64'h00},
    '{CFG_ROW,  4'd3,  ACT_SET_BIT,  6'd0,  3'd0, 8'h00, PREDICTED, 7'd0,  64'h00},
    '{WORD_ROW, 4'd0,  ACT_ALL_ON,   6'd0,  3'd0, 8'h00, PREDICTED, 7'd0,  64'h00},
    '{WORD_ROW, 4'd0,  ACT_SET_CHIP, 6'd0,  3'd2, 8'h0F, PREDICTED, 7'd0,  64'h00},
    '{CFG_ROW,  4'd8,  ACT_SET_BIT,  6'd0,  3'd0, 8'h00, PREDICTED, 7'd0,  64'h00},
    '{WORD_ROW, 4'd0,  ACT_SPARE_5,  6'd21, 3'd3, 8'h5A, PREDICTED, 7'd0,  64'h00},
    '{WORD_ROW, 4'd0,  ACT_SPARE_6,  6'd42, 3'd5, 8'hC3, PREDICTED, 7'd0,  64'h00},
    '{WORD_ROW, 4'd0,  ACT_SHIFT,    6'd0,  3'd0, 8'h00, PREDICTED, 7'd0,  64'h00}
  };

  // chip count per random segment, three idle mixes of four segments each
  localparam logic [CFG_W-1:0] SEG_CHIPS [0:11] = '{
    4'd8, 4'd1, 4'd4, 4'd15, 4'd0, 4'd6, 4'd2, 4'd5, 4'd8, 4'd12, 4'd7, 4'd3
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [CFG_W-1:0]    cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [ACTION_W-1:0] action = '0;
  logic [BITIDX_W-1:0] bit_index = '0;
  logic [CHIPIX_W-1:0] chip_index = '0;
  logic [BYTE_W-1:0]   value = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                serial_bit;
  logic                latch;

  // bench copy of the shadow store and chip count
  logic [BYTE_W-1:0] shadow_model [0:MAX_CHIPS-1];
  logic [CFG_W-1:0]  model_chips;

  serial_word_t expected_words [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int mismatch_count = 0;
  int words_checked  = 0;
  int items_sent     = 0;
  int shift_runs     = 0;
  int idle_cycles    = 0;

  shift_register_expander_driver #(.MAX_CHIPS(MAX_CHIPS)) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .bit_index  (bit_index),
    .chip_index (chip_index),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .serial_bit (serial_bit),
    .latch      (latch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int chips_active();
    return (int'(model_chips) > MAX_CHIPS) ? MAX_CHIPS : int'(model_chips);
  endfunction

  // apply one word to the shadow model, return the serial run it causes
  function automatic int shadow_step(input logic [ACTION_W-1:0] act,
      input logic [BITIDX_W-1:0] r, input logic [CHIPIX_W-1:0] c,
      input logic [BYTE_W-1:0] v, output logic [63:0] run);
    int n;
    int ri;
    int cnt;
    n = chips_active();
    ri = int'(r);
    cnt = 0;
    run = '0;
    case (act)
      ACT_SET_BIT: begin
        if (ri < n * BYTE_W)
          shadow_model[n - 1 - ri / BYTE_W][BYTE_W - 1 - ri % BYTE_W] = v[0];
      end
      ACT_SET_CHIP: begin
        if (int'(c) < n) shadow_model[n - 1 - int'(c)] = v;
      end
      ACT_ALL_OFF, ACT_ALL_ON: begin
        for (int i = 0; i < n; i++)
          shadow_model[i] = (act == ACT_ALL_ON) ? 8'hFF : 8'h00;
      end
      ACT_SHIFT: begin
        for (int i = 0; i < n; i++) begin
          for (int j = 0; j < BYTE_W; j++) begin
            run[cnt] = shadow_model[i][j];
            cnt++;
          end
        end
      end
      default: ;
    endcase
    return cnt;
  endfunction

  function automatic void queue_run(input logic [63:0] run, input int len);
    serial_word_t w;
    for (int i = 0; i < len; i++) begin
      w.serial_bit = run[i];
      w.latch = (i == len - 1);
      expected_words.push_back(w);
    end
  endfunction

  // offer one word, hold it until taken, then predict its serial run
  task automatic send_word(input logic [ACTION_W-1:0] act,
      input logic [BITIDX_W-1:0] r, input logic [CHIPIX_W-1:0] c,
      input logic [BYTE_W-1:0] v, input bit typed, input int typed_len,
      input logic [63:0] typed_run);
    logic [63:0] run;
    int len;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    action     <= act;
    bit_index  <= r;
    chip_index <= c;
    value      <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    len = shadow_step(act, r, c, v, run);
    if (typed) queue_run(typed_run, typed_len);
    else queue_run(run, len);
    items_sent++;
    if (act == ACT_SHIFT) shift_runs++;
  endtask

  // stop offering, wait for every expected word, then let the block settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_chip_count(input logic [CFG_W-1:0] chips);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= chips;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_chips = chips;
  endtask

  // mostly in-range edits and shifts, some out-of-range and spare codes
  task automatic random_word();
    logic [ACTION_W-1:0] act;
    logic [BITIDX_W-1:0] r;
    logic [CHIPIX_W-1:0] c;
    int n;
    int roll;
    n = chips_active();
    roll = $urandom_range(99);
    if (roll < 12) act = ACT_SHIFT;
    else if (roll < 17) act = ACT_ALL_OFF;
    else if (roll < 22) act = ACT_ALL_ON;
    else if (roll < 25) act = ACTION_W'($urandom_range(ACT_SPARE_5, ACT_SPARE_7));
    else if (roll < 62) act = ACT_SET_BIT;
    else act = ACT_SET_CHIP;
    if (n > 0 && $urandom_range(99) < 85) r = BITIDX_W'($urandom_range(n * BYTE_W - 1));
    else r = BITIDX_W'($urandom_range(63));
    if (n > 0 && $urandom_range(99) < 85) c = CHIPIX_W'($urandom_range(n - 1));
    else c = CHIPIX_W'($urandom_range(7));
    send_word(act, r, c, BYTE_W'($urandom_range(255)), PREDICTED, 0, '0);
  endtask

  // receiver: random stalls, plus a long hold-off when asked for
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic note_mismatch(input string what, input logic exp_v, input logic got_v);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch at %0t: %s expected %0b got %0b", $time, what, exp_v, got_v);
  endtask

  // output checker, in order against the oldest expectation
  always @(posedge clk) begin
    serial_word_t exp_w;
    if (!rst && out_valid && out_ready) begin
      words_checked++;
      if (expected_words.size() == 0) begin
        note_mismatch("unexpected serial word, latch", 1'b0, latch);
      end else begin
        exp_w = expected_words.pop_front();
        if (serial_bit !== exp_w.serial_bit)
          note_mismatch("serial_bit", exp_w.serial_bit, serial_bit);
        if (latch !== exp_w.latch)
          note_mismatch("latch", exp_w.latch, latch);
      end
    end
  end

  // watchdog on cycles with no handshake on any port
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("shift_register_expander_driver verification failed");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t row;
    int errors;
    for (int i = 0; i < MAX_CHIPS; i++) shadow_model[i] = '0;
    model_chips = 4'd1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table under the first idle mix
    send_idle_pct = 15;
    recv_idle_pct = 49;
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = DIRECTED_ROWS[i];
      if (row.is_cfg) write_chip_count(row.chips);
      else send_word(row.act, row.bit_idx, row.chip_idx, row.val, row.typed,
                     int'(row.run_len), row.run_bits);
    end

    // random words: three idle mixes, four chip counts each
    for (int m = 0; m < 3; m++) begin
      case (m)
        0: begin send_idle_pct = 15; recv_idle_pct = 49; end
        1: begin send_idle_pct = 49; recv_idle_pct = 15; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int s = 0; s < 4; s++) begin
        write_chip_count(SEG_CHIPS[m * 4 + s]);
        // long receiver hold-off while words keep coming, to back up the input
        if (m == 2 && s == 0) hold_requests++;
        for (int k = 0; k < SEG_WORDS; k++) begin
          if (k == SEG_WORDS / 2) drain_results();
          random_word();
        end
      end
    end

    drain_results();
    repeat (16) @(posedge clk);
    errors = mismatch_count + expected_words.size();
    $display("covered %0d input words, %0d shift-out runs, %0d serial words checked",
             items_sent, shift_runs, words_checked);
    $display("chip counts 0 to 15 across three idle mixes, %0d mismatches, %0d left over",
             mismatch_count, expected_words.size());
    if (errors == 0) begin
      $display("shift_register_expander_driver verification clean");
    end else begin
      $display("shift_register_expander_driver verification failed");
    end
    $finish;
  end

endmodule

FILE: shift_register_expander_driver.f
+incdir+rtl/core
rtl/core/sred_pkg.sv
rtl/core/sred_ctrl.sv
rtl/core/sred_datapath.sv
rtl/core/shift_register_expander_driver.sv
rtl/core/sred_checker.sv
tb/sv/shift_register_expander_driver_test.sv
